### design/ipv4_port_filter_classifier_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers for the port filter classifier.
// ----------------------------------------------------------------------------
`ifndef IPV4_PORT_FILTER_CLASSIFIER_MACROS_SVH
`define IPV4_PORT_FILTER_CLASSIFIER_MACROS_SVH

`ifndef NO_ASSERTIONS

`define IPFC_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("ipfc assertion failed");

`define IPFC_ASSERT_NEVER(lbl, clk, rstn, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
    else $error("ipfc forbidden condition seen");

`else

`define IPFC_ASSERT(lbl, clk, rstn, prop)

`define IPFC_ASSERT_NEVER(lbl, clk, rstn, cond)

`endif

`endif

### design/ipfc_pkg.sv
// ----------------------------------------------------------------------------
// ipfc_pkg
// Types and constants of the IPv4 port filter classifier.
// ----------------------------------------------------------------------------
`default_nettype none

package ipfc_pkg;

  localparam int unsigned MAX_SLOTS = 6;
  localparam int unsigned ADDR_W    = 5;
  localparam int unsigned QDEPTH    = 4;
  localparam int unsigned QPTR_W    = 2;

  localparam logic [2:0] REG_PORT_A      = 3'd0;
  localparam logic [2:0] REG_CAPTURE_LEN = 3'd6;

  localparam logic [15:0] PORT_RESET [MAX_SLOTS] = '{
    16'd5000, 16'd80, 16'd0, 16'd0, 16'd0, 16'd0
  };
  localparam logic [11:0] CAPTURE_LEN_RESET = 12'd500;

  localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
  localparam logic [7:0]  PROTO_TCP      = 8'd6;
  localparam logic [7:0]  PROTO_UDP      = 8'd17;
  localparam logic [15:0] MIN_FRAME_LEN  = 16'd34;
  localparam logic [3:0]  MIN_IHL        = 4'd5;
  localparam logic [6:0]  MAC_HDR_BYTES  = 7'd14;
  localparam logic [6:0]  TCP_MIN_LEN    = 7'd20;
  localparam logic [6:0]  UDP_HDR_LEN    = 7'd8;

  localparam logic [15:0] POS_ETYPE_HI = 16'd12;
  localparam logic [15:0] POS_ETYPE_LO = 16'd13;
  localparam logic [15:0] POS_IHL      = 16'd14;
  localparam logic [15:0] POS_PROTO    = 16'd23;
  localparam logic [15:0] COUNT_MAX    = 16'hFFFF;

  localparam logic [15:0] REL_SRC_HI = 16'd0;
  localparam logic [15:0] REL_SRC_LO = 16'd1;
  localparam logic [15:0] REL_DST_HI = 16'd2;
  localparam logic [15:0] REL_DST_LO = 16'd3;
  localparam logic [15:0] REL_DOFF   = 16'd12;

  typedef enum logic [2:0] {
    VERDICT_NOT_IPV4      = 3'd0,
    VERDICT_BAD_L4        = 3'd1,
    VERDICT_PORT_MISS     = 3'd2,
    VERDICT_SHORT_PAYLOAD = 3'd3,
    VERDICT_EXPORT        = 3'd4
  } verdict_e;

  typedef struct packed {
    logic [15:0] len;
    logic [15:0] ether;
    logic [3:0]  ihl;
    logic [7:0]  proto;
    logic [15:0] sp;
    logic [15:0] dp;
    logic [3:0]  doff;
  } frame_rec_t;

  typedef struct packed {
    verdict_e    verdict;
    logic [15:0] sp;
    logic [15:0] dp;
    logic [7:0]  offset;
    logic [15:0] len;
  } result_t;

endpackage

`default_nettype wire

### design/ipfc_front.sv
// ----------------------------------------------------------------------------
// ipfc_front
// Byte-wise header capture; emits one frame record at the last byte.
// ----------------------------------------------------------------------------
`default_nettype none

module ipfc_front
  import ipfc_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       push,
  input  wire logic [7:0] data_byte_i,
  input  wire logic       last_byte_i,
  input  wire logic       q_full_i,
  output logic            q_push_o,
  output frame_rec_t      q_rec_o
);

  logic        accept;
  logic [15:0] cnt_q, cnt_d;
  logic [15:0] ether_q, ether_d;
  logic [3:0]  ihl_q, ihl_d;
  logic [7:0]  proto_q, proto_d;
  logic [15:0] sp_q, sp_d;
  logic [15:0] dp_q, dp_d;
  logic [3:0]  doff_q, doff_d;
  logic [6:0]  l4_base;
  logic [15:0] rel;

  assign accept = push & ~q_full_i;

  always_comb begin
    ether_d = ether_q;
    ihl_d   = ihl_q;
    proto_d = proto_q;
    sp_d    = sp_q;
    dp_d    = dp_q;
    doff_d  = doff_q;
    if (cnt_q == POS_ETYPE_HI) begin
      ether_d[15:8] = data_byte_i;
    end
    if (cnt_q == POS_ETYPE_LO) begin
      ether_d[7:0] = data_byte_i;
    end
    if (cnt_q == POS_IHL) begin
      ihl_d = data_byte_i[3:0];
    end
    if (cnt_q == POS_PROTO) begin
      proto_d = data_byte_i;
    end
    l4_base = MAC_HDR_BYTES + {1'b0, ihl_d, 2'b00};
    rel     = cnt_q - {9'd0, l4_base};
    case (rel)
      REL_SRC_HI: sp_d[15:8] = data_byte_i;
      REL_SRC_LO: sp_d[7:0]  = data_byte_i;
      REL_DST_HI: dp_d[15:8] = data_byte_i;
      REL_DST_LO: dp_d[7:0]  = data_byte_i;
      REL_DOFF:   doff_d     = data_byte_i[7:4];
      default: ;
    endcase
    cnt_d = (cnt_q != COUNT_MAX) ? cnt_q + 16'd1 : cnt_q;
  end

  assign q_push_o      = accept & last_byte_i;
  assign q_rec_o.len   = cnt_d;
  assign q_rec_o.ether = ether_d;
  assign q_rec_o.ihl   = ihl_d;
  assign q_rec_o.proto = proto_d;
  assign q_rec_o.sp    = sp_d;
  assign q_rec_o.dp    = dp_d;
  assign q_rec_o.doff  = doff_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q   <= '0;
      ether_q <= '0;
      ihl_q   <= '0;
      proto_q <= '0;
      sp_q    <= '0;
      dp_q    <= '0;
      doff_q  <= '0;
    end else if (accept) begin
      if (last_byte_i) begin
        cnt_q   <= '0;
        ether_q <= '0;
        ihl_q   <= '0;
        proto_q <= '0;
        sp_q    <= '0;
        dp_q    <= '0;
        doff_q  <= '0;
      end else begin
        cnt_q   <= cnt_d;
        ether_q <= ether_d;
        ihl_q   <= ihl_d;
        proto_q <= proto_d;
        sp_q    <= sp_d;
        dp_q    <= dp_d;
        doff_q  <= doff_d;
      end
    end
  end

endmodule

`default_nettype wire

### design/ipfc_queue.sv
// ----------------------------------------------------------------------------
// ipfc_queue
// Short first-word-fall-through queue of frame records between the parts.
// ----------------------------------------------------------------------------
`default_nettype none
`include "ipv4_port_filter_classifier_macros.svh"

module ipfc_queue
  import ipfc_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        wr_en_i,
  input  wire frame_rec_t  wr_rec_i,
  output logic             full_o,
  input  wire logic        rd_en_i,
  output frame_rec_t       rd_rec_o,
  output logic             empty_o
);

  frame_rec_t        mem [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_q;
  logic [QPTR_W-1:0] rd_ptr_q;
  logic [QPTR_W:0]   count_q, count_d;
  logic              do_wr, do_rd;

  assign full_o   = (count_q == (QPTR_W+1)'(QDEPTH));
  assign empty_o  = (count_q == '0);
  assign do_wr    = wr_en_i & ~full_o;
  assign do_rd    = rd_en_i & ~empty_o;
  assign rd_rec_o = mem[rd_ptr_q];

  always_comb begin
    count_d = count_q;
    if (do_wr && !do_rd) begin
      count_d = count_q + 1'b1;
    end else if (do_rd && !do_wr) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem[wr_ptr_q] <= wr_rec_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (do_rd) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      count_q <= count_d;
    end
  end

  `IPFC_ASSERT_NEVER(a_count_bound, clk_i, rst_ni, count_q > (QPTR_W+1)'(QDEPTH))
  `IPFC_ASSERT(a_count_up, clk_i, rst_ni, do_wr && !do_rd |=> count_q == $past(count_q) + 1'b1)
  `IPFC_ASSERT(a_ptr_gap, clk_i, rst_ni, !full_o |-> (wr_ptr_q - rd_ptr_q) == count_q[QPTR_W-1:0])

endmodule

`default_nettype wire

### design/ipfc_back.sv
// ----------------------------------------------------------------------------
// ipfc_back
// Verdict logic for one frame record, with the registered result stage.
// ----------------------------------------------------------------------------
`default_nettype none

module ipfc_back
  import ipfc_pkg::*;
#(
  parameter int unsigned PORT_SLOTS = 6
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire frame_rec_t  rec_i,
  input  wire logic        rec_empty_i,
  output logic             rec_pop_o,
  input  wire logic [11:0] cap_len_i,
  input  wire logic [15:0] slots_i [MAX_SLOTS],
  input  wire logic        pop,
  output logic             empty,
  output result_t          res_o
);

  logic        out_valid_q;
  result_t     out_q, res_d;
  logic        load;
  logic        is_tcp, is_udp, is_l4;
  logic [6:0]  hdr_end;
  logic [6:0]  l4_min;
  logic [7:0]  need;
  logic [6:0]  tl;
  logic [7:0]  offset;
  logic [15:0] sp, dp;
  logic        not_ip, bad, listed, short_pl;

  assign load      = ~out_valid_q | pop;
  assign rec_pop_o = load & ~rec_empty_i;
  assign empty     = ~out_valid_q;
  assign res_o     = out_q;

  always_comb begin
    is_tcp  = (rec_i.proto == PROTO_TCP);
    is_udp  = (rec_i.proto == PROTO_UDP);
    is_l4   = is_tcp | is_udp;
    hdr_end = MAC_HDR_BYTES + {1'b0, rec_i.ihl, 2'b00};
    l4_min  = is_tcp ? TCP_MIN_LEN : UDP_HDR_LEN;
    need    = {1'b0, hdr_end} + {1'b0, l4_min};
    tl      = is_tcp ? {1'b0, rec_i.doff, 2'b00} : (is_udp ? UDP_HDR_LEN : 7'd0);
    offset  = {1'b0, hdr_end} + {1'b0, tl};
    sp      = is_l4 ? rec_i.sp : 16'd0;
    dp      = is_l4 ? rec_i.dp : 16'd0;
    not_ip  = (rec_i.len < MIN_FRAME_LEN) || (rec_i.ether != ETHERTYPE_IPV4);
    bad     = is_l4 && ((rec_i.ihl < MIN_IHL) || ({8'd0, need} > rec_i.len));
    listed  = 1'b0;
    for (int i = 0; i < PORT_SLOTS; i++) begin
      listed = listed | (slots_i[i] == sp) | (slots_i[i] == dp);
    end
    short_pl = ({9'd0, offset} + {5'd0, cap_len_i}) > {1'b0, rec_i.len};

    res_d.len    = rec_i.len;
    res_d.sp     = sp;
    res_d.dp     = dp;
    res_d.offset = offset;
    if (not_ip || bad) begin
      res_d.verdict = not_ip ? VERDICT_NOT_IPV4 : VERDICT_BAD_L4;
      res_d.sp      = '0;
      res_d.dp      = '0;
      res_d.offset  = '0;
    end else if (!listed) begin
      res_d.verdict = VERDICT_PORT_MISS;
    end else if (short_pl) begin
      res_d.verdict = VERDICT_SHORT_PAYLOAD;
    end else begin
      res_d.verdict = VERDICT_EXPORT;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rec_pop_o) begin
      out_q <= res_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load) begin
      out_valid_q <= ~rec_empty_i;
    end
  end

endmodule

`default_nettype wire

### design/ipv4_port_filter_classifier.sv
// ----------------------------------------------------------------------------
// ipv4_port_filter_classifier
// Ethernet/IPv4 TCP-UDP header parser with a monitored-port filter.
// ----------------------------------------------------------------------------
// Frames enter one byte per cycle on the push side while full is low, with
// last_byte_i marking the final byte; the byte after the last byte of a
// frame starts a new frame. At the last byte the front part hands one frame
// record to a four-entry queue; the back part turns it into a verdict
// combinationally and holds it in the result register, so a result is
// visible only after both its queue entry and the result register are
// written. full is raised whenever the queue holds four records and then
// holds every byte, not only a last byte. Verdicts: 0 not IPv4 or short,
// 1 bad transport header, 2 port not listed, 3 payload shorter than
// capture_len, 4 exported. Registers: port slots a..f at byte addresses
// 0x00..0x14, capture_len at 0x18.
// ----------------------------------------------------------------------------
`default_nettype none

module ipv4_port_filter_classifier
  import ipfc_pkg::*;
#(
  parameter int unsigned PORT_SLOTS = 6
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [ADDR_W-1:0] paddr,
  input  wire logic [31:0]       pwdata,
  output logic [31:0]            prdata,
  output logic                   pready,
  input  wire logic              push,
  output logic                   full,
  input  wire logic [7:0]        data_byte_i,
  input  wire logic              last_byte_i,
  output logic                   empty,
  input  wire logic              pop,
  output logic [2:0]             verdict_o,
  output logic [15:0]            source_port_o,
  output logic [15:0]            dst_port_o,
  output logic [7:0]             pl_offset_o,
  output logic [15:0]            frame_length_o
);

  logic [15:0] slot_q [MAX_SLOTS];
  logic [11:0] cap_len_q;
  logic [2:0]  reg_idx;
  logic        reg_wr;
  logic        q_push, q_full, q_pop, q_empty;
  frame_rec_t  q_wr_rec, q_rd_rec;
  result_t     res;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];
  assign reg_wr  = psel & penable & pwrite & pready;

  for (genvar i = 0; i < MAX_SLOTS; i++) begin : g_slot
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        slot_q[i] <= PORT_RESET[i];
      end else if (reg_wr && reg_idx == REG_PORT_A + 3'(i)) begin
        slot_q[i] <= pwdata[15:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_len_q <= CAPTURE_LEN_RESET;
    end else if (reg_wr && reg_idx == REG_CAPTURE_LEN) begin
      cap_len_q <= pwdata[11:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (reg_idx == REG_CAPTURE_LEN) begin
      prdata = {20'd0, cap_len_q};
    end
    for (int i = 0; i < MAX_SLOTS; i++) begin
      if (reg_idx == REG_PORT_A + 3'(i)) begin
        prdata = {16'd0, slot_q[i]};
      end
    end
  end

  ipfc_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .data_byte_i (data_byte_i),
    .last_byte_i (last_byte_i),
    .q_full_i    (q_full),
    .q_push_o    (q_push),
    .q_rec_o     (q_wr_rec)
  );

  ipfc_queue u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .wr_en_i  (q_push),
    .wr_rec_i (q_wr_rec),
    .full_o   (q_full),
    .rd_en_i  (q_pop),
    .rd_rec_o (q_rd_rec),
    .empty_o  (q_empty)
  );

  ipfc_back #(
    .PORT_SLOTS (PORT_SLOTS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .rec_i       (q_rd_rec),
    .rec_empty_i (q_empty),
    .rec_pop_o   (q_pop),
    .cap_len_i   (cap_len_q),
    .slots_i     (slot_q),
    .pop         (pop),
    .empty       (empty),
    .res_o       (res)
  );

  assign full           = q_full;
  assign verdict_o      = res.verdict;
  assign source_port_o  = res.sp;
  assign dst_port_o     = res.dp;
  assign pl_offset_o    = res.offset;
  assign frame_length_o = res.len;

endmodule

`default_nettype wire

### tb/sv/ipv4_port_filter_classifier_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ipv4_port_filter_classifier_tb
// Feeds Ethernet frames byte by byte, predicts one verdict per frame in a
// local classifier and checks every result transfer field by field, across
// several port-list and capture-window settings.
// ----------------------------------------------------------------------------

module ipv4_port_filter_classifier_tb;
  import ipfc_pkg::*;

  localparam int unsigned SLOTS_USED  = 6;
  localparam int unsigned QUIET_LIMIT = 4000;
  localparam int unsigned HOLD_CYCLES = 400;
  localparam logic [2:0]  REG_NONE    = 3'd7;
  localparam logic [7:0]  PROTO_ICMP  = 8'd1;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } frame_byte_t;

  logic              clk_i          = 1'b0;
  logic              rst_ni         = 1'b0;
  logic              psel           = 1'b0;
  logic              penable        = 1'b0;
  logic              pwrite         = 1'b0;
  logic [ADDR_W-1:0] paddr          = '0;
  logic [31:0]       pwdata         = '0;
  logic [31:0]       prdata;
  logic              pready;
  logic              push           = 1'b0;
  logic              full;
  logic [7:0]        data_byte_i    = '0;
  logic              last_byte_i    = 1'b0;
  logic              empty;
  logic              pop            = 1'b0;
  logic [2:0]        verdict_o;
  logic [15:0]       source_port_o;
  logic [15:0]       dst_port_o;
  logic [7:0]        pl_offset_o;
  logic [15:0]       frame_length_o;

  frame_byte_t byte_stream [$];
  result_t     verdict_due [$];

  logic [15:0] port_slot [MAX_SLOTS];
  logic [11:0] cap_len;

  logic [15:0] fr_count = '0;
  logic [15:0] fr_ether = '0;
  logic [3:0]  fr_ihl   = '0;
  logic [7:0]  fr_proto = '0;
  logic [15:0] fr_sp    = '0;
  logic [15:0] fr_dp    = '0;
  logic [3:0]  fr_doff  = '0;

  int unsigned mismatches   = 0;
  int unsigned quiet_cycles = 0;
  int unsigned hold_left    = 0;
  bit          calm         = 1'b0;
  bit          stall_wanted = 1'b0;
  bit          stall_done   = 1'b0;

  ipv4_port_filter_classifier #(
    .PORT_SLOTS(SLOTS_USED)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .push          (push),
    .full          (full),
    .data_byte_i   (data_byte_i),
    .last_byte_i   (last_byte_i),
    .empty         (empty),
    .pop           (pop),
    .verdict_o     (verdict_o),
    .source_port_o (source_port_o),
    .dst_port_o    (dst_port_o),
    .pl_offset_o   (pl_offset_o),
    .frame_length_o(frame_length_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Capture header fields of one byte; on the last byte queue the verdict.
  function automatic void classify_byte(input logic [7:0] b, input logic last);
    int unsigned pos, t, len, ihl_b, tl, off;
    logic [15:0] sp, dp;
    bit          bad, hit;
    result_t     r;
    pos = fr_count;
    if (pos == 12) fr_ether[15:8] = b;
    if (pos == 13) fr_ether[7:0] = b;
    if (pos == 14) fr_ihl = b[3:0];
    if (pos == 23) fr_proto = b;
    t = 14 + 4 * fr_ihl;
    if (pos == t) fr_sp[15:8] = b;
    if (pos == t + 1) fr_sp[7:0] = b;
    if (pos == t + 2) fr_dp[15:8] = b;
    if (pos == t + 3) fr_dp[7:0] = b;
    if (pos == t + 12) fr_doff = b[7:4];
    if (fr_count != COUNT_MAX) fr_count = fr_count + 16'd1;
    if (!last) return;

    len   = fr_count;
    ihl_b = 4 * fr_ihl;
    tl    = 0;
    off   = 0;
    sp    = '0;
    dp    = '0;
    if (len < 34 || fr_ether != ETHERTYPE_IPV4) begin
      r.verdict = VERDICT_NOT_IPV4;
    end else begin
      bad = 1'b0;
      if (fr_proto == PROTO_TCP) begin
        bad = (ihl_b < 20) || (34 + ihl_b > len);
        tl  = 4 * fr_doff;
      end else if (fr_proto == PROTO_UDP) begin
        bad = (ihl_b < 20) || (22 + ihl_b > len);
        tl  = 8;
      end
      if (bad) begin
        r.verdict = VERDICT_BAD_L4;
      end else begin
        if (fr_proto == PROTO_TCP || fr_proto == PROTO_UDP) begin
          sp = fr_sp;
          dp = fr_dp;
        end
        off = 14 + ihl_b + tl;
        hit = 1'b0;
        for (int i = 0; i < SLOTS_USED; i++) begin
          if (port_slot[i] == sp || port_slot[i] == dp) hit = 1'b1;
        end
        if (!hit) r.verdict = VERDICT_PORT_MISS;
        else if (off + cap_len > len) r.verdict = VERDICT_SHORT_PAYLOAD;
        else r.verdict = VERDICT_EXPORT;
      end
    end
    r.sp     = sp;
    r.dp     = dp;
    r.offset = off[7:0];
    r.len    = len[15:0];
    verdict_due.push_back(r);

    fr_count = '0;
    fr_ether = '0;
    fr_ihl   = '0;
    fr_proto = '0;
    fr_sp    = '0;
    fr_dp    = '0;
    fr_doff  = '0;
  endfunction

  task automatic report_mismatch(input string field, input int unsigned got,
                                 input int unsigned want);
    mismatches++;
    $display("%0t: %s mismatch, got %0d, want %0d", $time, field, got, want);
  endtask

  // Sender: present the oldest pending byte.
  always @(negedge clk_i) begin
    if (!rst_ni || byte_stream.size() == 0 || (!calm && $urandom_range(99) < 7)) begin
      push <= 1'b0;
    end else begin
      push        <= 1'b1;
      data_byte_i <= byte_stream[0].data;
      last_byte_i <= byte_stream[0].last;
    end
  end

  // Receiver: pop at random, hold off once for a long stretch.
  always @(negedge clk_i) begin
    if (hold_left != 0) begin
      hold_left = hold_left - 1;
      pop <= 1'b0;
    end else if (stall_wanted && !stall_done) begin
      hold_left  = HOLD_CYCLES;
      stall_done = 1'b1;
      pop <= 1'b0;
    end else begin
      pop <= rst_ni && (calm || $urandom_range(99) >= 7);
    end
  end

  // Track input transfers and check result transfers.
  always @(posedge clk_i) begin
    result_t want;
    if (!rst_ni) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (push && !full) begin
        classify_byte(data_byte_i, last_byte_i);
        void'(byte_stream.pop_front());
        quiet_cycles = 0;
      end
      if (pop && !empty) begin
        quiet_cycles = 0;
        if (verdict_due.size() == 0) begin
          report_mismatch("unexpected result, verdict", verdict_o, 0);
        end else begin
          want = verdict_due.pop_front();
          if (verdict_o !== want.verdict) report_mismatch("verdict", verdict_o, want.verdict);
          if (source_port_o !== want.sp) report_mismatch("source_port", source_port_o, want.sp);
          if (dst_port_o !== want.dp) report_mismatch("dst_port", dst_port_o, want.dp);
          if (pl_offset_o !== want.offset)
            report_mismatch("pl_offset", pl_offset_o, want.offset);
          if (frame_length_o !== want.len)
            report_mismatch("frame_length", frame_length_o, want.len);
        end
      end
    end
  end

  initial begin
    while (quiet_cycles < QUIET_LIMIT) @(negedge clk_i);
    $display("%0t: no transfer for %0d cycles", $time, QUIET_LIMIT);
    $display("[FAIL] regression broken");
    $finish;
  end

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (idx < MAX_SLOTS) port_slot[idx] = value[15:0];
    else if (idx == REG_CAPTURE_LEN) cap_len = value[11:0];
  endtask

  // Build one frame of n bytes; header fields land where the frame reaches them.
  task automatic put_frame(input int unsigned n, input logic [15:0] etype,
                           input logic [3:0] ihl, input logic [7:0] proto,
                           input logic [15:0] sp, input logic [15:0] dp,
                           input logic [3:0] doff, input int fill);
    logic [7:0]  fr [];
    int unsigned t;
    fr = new[n];
    foreach (fr[i]) fr[i] = (fill < 0) ? 8'($urandom) : 8'(fill);
    t = 14 + 4 * ihl;
    if (n > 12) fr[12] = etype[15:8];
    if (n > 13) fr[13] = etype[7:0];
    if (n > 23) fr[23] = proto;
    if (n > t) fr[t] = sp[15:8];
    if (n > t + 1) fr[t + 1] = sp[7:0];
    if (n > t + 2) fr[t + 2] = dp[15:8];
    if (n > t + 3) fr[t + 3] = dp[7:0];
    if (n > t + 12) fr[t + 12] = {doff, fr[t + 12][3:0]};
    if (n > 14) fr[14] = {4'h4, ihl};
    for (int unsigned i = 0; i < n; i++) byte_stream.push_back('{fr[i], i == n - 1});
  endtask

  function automatic logic [15:0] pick_port();
    case ($urandom_range(2))
      0:       return port_slot[$urandom_range(MAX_SLOTS - 1)];
      1:       return $urandom_range(1) ? 16'hFFFF : 16'h0000;
      default: return 16'($urandom);
    endcase
  endfunction

  // Mostly well-formed TCP/UDP frames; some foreign, other-protocol or cut short.
  task automatic random_frame(input int unsigned max_pay);
    int unsigned pick, hdr, n;
    logic [15:0] etype;
    logic [7:0]  proto;
    logic [3:0]  ihl, doff;
    pick  = $urandom_range(99);
    etype = ETHERTYPE_IPV4;
    proto = $urandom_range(1) ? PROTO_TCP : PROTO_UDP;
    ihl   = ($urandom_range(9) == 0) ? 4'($urandom_range(15)) : 4'd5;
    doff  = ($urandom_range(7) == 0) ? 4'($urandom_range(15)) : 4'd5;
    if (pick < 8) etype = 16'($urandom);
    else if (pick < 18) proto = 8'($urandom);
    hdr = 14 + 4 * ihl + ((proto == PROTO_TCP) ? ((doff < 5) ? 20 : 4 * doff) : 8);
    n   = hdr + $urandom_range(max_pay);
    if (pick >= 18 && pick < 28) n = $urandom_range(hdr + 2, 1);
    put_frame(n, etype, ihl, proto, pick_port(), pick_port(), doff, -1);
  endtask

  task automatic settle();
    while (byte_stream.size() != 0 || verdict_due.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  initial begin
    foreach (port_slot[i]) port_slot[i] = PORT_RESET[i];
    cap_len = CAPTURE_LEN_RESET;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed frames against the reset port list and capture window.
    put_frame(1, ETHERTYPE_IPV4, 4'd5, PROTO_TCP, 16'd80, 16'd80, 4'd5, -1);
    put_frame(33, ETHERTYPE_IPV4, 4'd5, PROTO_TCP, 16'd80, 16'd80, 4'd5, -1);
    put_frame(34, 16'h86DD, 4'd5, PROTO_TCP, 16'd80, 16'd80, 4'd5, -1);
    put_frame(34, ETHERTYPE_IPV4, 4'd5, PROTO_TCP, 16'd80, 16'd80, 4'd5, -1);
    put_frame(34, ETHERTYPE_IPV4, 4'd4, PROTO_TCP, 16'd80, 16'd1234, 4'd5, -1);
    put_frame(34, ETHERTYPE_IPV4, 4'd0, PROTO_UDP, 16'd80, 16'd1234, 4'd5, -1);
    put_frame(41, ETHERTYPE_IPV4, 4'd5, PROTO_UDP, 16'd5000, 16'd7, 4'd5, -1);
    put_frame(42, ETHERTYPE_IPV4, 4'd5, PROTO_UDP, 16'd5000, 16'd7, 4'd5, -1);
    put_frame(42, ETHERTYPE_IPV4, 4'd5, PROTO_UDP, 16'd1111, 16'd2222, 4'd5, -1);
    put_frame(34, ETHERTYPE_IPV4, 4'd3, PROTO_ICMP, 16'd1111, 16'd2222, 4'd5, -1);
    put_frame(94, ETHERTYPE_IPV4, 4'd15, PROTO_TCP, 16'd80, 16'd80, 4'd15, -1);
    put_frame(34, 16'hFFFF, 4'd15, 8'hFF, 16'hFFFF, 16'hFFFF, 4'd15, 255);
    settle();

    // Random port list, zero capture window, no idling on either side.
    for (int i = 0; i < MAX_SLOTS; i++) write_reg(REG_PORT_A + 3'(i), $urandom);
    write_reg(REG_CAPTURE_LEN, $urandom & 32'hFFFF_F000);
    write_reg(REG_NONE, $urandom);
    calm = 1'b1;
    put_frame(60, ETHERTYPE_IPV4, 4'd5, PROTO_TCP, port_slot[0], 16'd1234, 4'd2, -1);
    random_frame(6);
    settle();
    calm = 1'b0;

    // Extreme settings; the receiver holds off so the input side fills up.
    write_reg(REG_PORT_A, {16'($urandom), 16'h0000});
    for (int i = 1; i < MAX_SLOTS; i++) write_reg(REG_PORT_A + 3'(i), 32'hFFFF_FFFF);
    write_reg(REG_CAPTURE_LEN, 32'hFFFF_FFFF);
    stall_wanted = 1'b1;
    repeat (10) begin
      put_frame($urandom_range(8, 1), ETHERTYPE_IPV4, 4'd5, PROTO_TCP,
                pick_port(), pick_port(), 4'd5, -1);
    end
    settle();

    for (int i = 0; i < MAX_SLOTS; i++)
      write_reg(REG_PORT_A + 3'(i), ($urandom_range(3) == 0) ? 32'd0 : $urandom);
    write_reg(REG_CAPTURE_LEN, $urandom_range(60));
    random_frame(10);
    settle();

    repeat (10) @(posedge clk_i);
    if (mismatches == 0 && verdict_due.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
